// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console writer: payload structs, action codes,
// character codes and reset values. No dependencies.
`default_nettype none

package tcw_pkg;

  // Screen size defaults
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 12;
  localparam int ATTR_W = 8;

  // Config port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEXT_COLOR     = 1'b0,
    REG_CURSOR_VISIBLE = 1'b1
  } cfg_reg_t;

  localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h8F;

  // Control characters
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;

  typedef enum logic {
    ACT_PUT_CHAR   = 1'b0,
    ACT_SET_CURSOR = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [CHAR_W-1:0] write_symbol;
    logic [ATTR_W-1:0] write_color;
    logic [ADDR_W-1:0] cursor_address;
    logic              position_accepted;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_writer_core.sv =====
// Text console writer top level: cursor tracking, cell write generation,
// two-entry output buffer. Depends on tcw_pkg.
//
// Takes one word per clock cycle while in_ready is high: each put-character or
// set-cursor word is handled in a single pass of logic from the cursor registers
// to the result register. A skid register behind the output register lets one
// more word enter while a result is stalled; in_ready drops only when both are
// full. The cursor address multiply (row times COLUMNS) is the longest path.
// Config writes are always accepted (cfg_ready is tied high) and must only be
// issued while the block is idle. With the cursor hidden, cursor_address
// carries the cell count COLUMNS*ROWS truncated to 12 bits.
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire tcw_pkg::in_item_t                in_item,
  // output channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tcw_pkg::out_item_t                    out_item,
  // config channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL    = tcw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW    = tcw_pkg::ROW_W'(ROWS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A      = tcw_pkg::ADDR_W'(COLUMNS);
  localparam logic [tcw_pkg::ADDR_W-1:0] HIDDEN_ADDR =
    tcw_pkg::ADDR_W'((COLUMNS * ROWS) % (1 << tcw_pkg::ADDR_W));

  // Config registers
  logic [tcw_pkg::ATTR_W-1:0] text_color;
  logic                       cursor_visible;

  // Cursor
  logic [tcw_pkg::COL_W-1:0] cursor_col, cursor_col_next;
  logic [tcw_pkg::ROW_W-1:0] cursor_row, cursor_row_next;

  // Output buffering
  tcw_pkg::out_item_t result;
  tcw_pkg::out_item_t skid_item;
  logic               skid_valid;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color     <= tcw_pkg::TEXT_COLOR_RESET;
      cursor_visible <= 1'b0;
    end else if (cfg_valid) begin
      unique case (tcw_pkg::cfg_reg_t'(cfg_index))
        tcw_pkg::REG_TEXT_COLOR:     text_color     <= cfg_data;
        tcw_pkg::REG_CURSOR_VISIBLE: cursor_visible <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Cursor move and cell write
  always_comb begin
    cursor_col_next          = cursor_col;
    cursor_row_next          = cursor_row;
    result.write_enable      = 1'b0;
    result.write_address     = '0;
    result.write_symbol      = '0;
    result.write_color       = '0;
    result.position_accepted = 1'b1;
    unique case (in_item.action)
      tcw_pkg::ACT_PUT_CHAR: begin
        priority if (in_item.char_code == tcw_pkg::CODE_NEWLINE) begin
          // newline is ignored on the last row
          if (cursor_row < LAST_ROW) begin
            cursor_row_next = cursor_row + 1'b1;
            cursor_col_next = '0;
          end
        end else if (in_item.char_code == tcw_pkg::CODE_BACKSPACE) begin
          // back one cell, wrapping up a row, stuck at top-left
          if (cursor_col == '0) begin
            if (cursor_row != '0) begin
              cursor_row_next = cursor_row - 1'b1;
              cursor_col_next = LAST_COL;
            end
          end else begin
            cursor_col_next = cursor_col - 1'b1;
          end
        end else begin
          result.write_enable  = 1'b1;
          result.write_address = tcw_pkg::ADDR_W'(cursor_row) * COLS_A
                                 + tcw_pkg::ADDR_W'(cursor_col);
          result.write_symbol  = in_item.char_code;
          result.write_color   = text_color;
          // advance, no scrolling at bottom-right
          if (cursor_col >= LAST_COL) begin
            if (cursor_row < LAST_ROW) begin
              cursor_row_next = cursor_row + 1'b1;
              cursor_col_next = '0;
            end
          end else begin
            cursor_col_next = cursor_col + 1'b1;
          end
        end
      end
      tcw_pkg::ACT_SET_CURSOR: begin
        if ({1'b0, in_item.column} < 8'(COLUMNS) && {1'b0, in_item.row} < 6'(ROWS)) begin
          cursor_col_next = in_item.column;
          cursor_row_next = in_item.row;
        end else begin
          result.position_accepted = 1'b0;
        end
      end
      default: ;
    endcase
    result.cursor_address = cursor_visible
                            ? tcw_pkg::ADDR_W'(cursor_row_next) * COLS_A
                              + tcw_pkg::ADDR_W'(cursor_col_next)
                            : HIDDEN_ADDR;
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (accept) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payloads
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (accept) begin
        out_item <= result;
      end
    end else if (accept) begin
      skid_item <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core.
`default_nettype none

module tcw_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tcw_pkg::out_item_t out_item
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output word changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // No cell write leaves the write fields cleared
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.write_enable |->
      out_item.write_address == '0 && out_item.write_symbol == '0 &&
      out_item.write_color == '0)
    else $error("write fields set without a cell write");

  // Cell writes never carry the newline or backspace code, nor a rejected position
  a_write_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.write_enable |->
      out_item.position_accepted &&
      out_item.write_symbol != tcw_pkg::CODE_NEWLINE &&
      out_item.write_symbol != tcw_pkg::CODE_BACKSPACE)
    else $error("cell write of a control code");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
